// File: hdl/capture_compare_pwm_unit_defines.svh
// Assertion macros for the capture/compare/PWM unit.
`ifndef CAPTURE_COMPARE_PWM_UNIT_DEFINES_SVH
`define CAPTURE_COMPARE_PWM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define CCP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);
// checked on every edge, reset included
`define CCP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) expr) else $error(msg);
`else
`define CCP_ASSERT(label, expr, msg)
`define CCP_ASSERT_ALWAYS(label, expr, msg)
`endif
`endif

// File: hdl/ccp_pkg.sv
// Types and codes shared by the capture/compare/PWM unit.
`timescale 1ns / 1ps
package ccp_pkg;

  // request kinds
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_PIN       = 3'd1;
  localparam logic [2:0] REQ_PWM_MATCH = 3'd2;
  localparam logic [2:0] REQ_CAN_CAP   = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;
  localparam logic [2:0] REQ_WRITE     = 3'd5;

  // register selectors
  localparam logic [2:0] SEL_VAL_HI  = 3'd0;
  localparam logic [2:0] SEL_VAL_LO  = 3'd1;
  localparam logic [2:0] SEL_CONTROL = 3'd2;
  localparam logic [2:0] SEL_TMR_SEL = 3'd3;

  // mode codes (control bits 3..0)
  localparam logic [3:0] MODE_CMP_TOGGLE  = 4'd2;
  localparam logic [3:0] MODE_CAP_FALL    = 4'd4;
  localparam logic [3:0] MODE_CAP_4TH     = 4'd6;
  localparam logic [3:0] MODE_CAP_16TH    = 4'd7;
  localparam logic [3:0] MODE_CMP_SET     = 4'd8;
  localparam logic [3:0] MODE_CMP_CLR     = 4'd9;
  localparam logic [3:0] MODE_CMP_SWI     = 4'd10;
  localparam logic [3:0] MODE_CMP_SPECIAL = 4'd11;

  // timer numbers
  localparam logic [2:0] TMR1 = 3'd1;
  localparam logic [2:0] TMR2 = 3'd2;
  localparam logic [2:0] TMR3 = 3'd3;
  localparam logic [2:0] TMR4 = 3'd4;

  // pin drive codes
  localparam logic [1:0] PIN_LOW  = 2'd0;
  localparam logic [1:0] PIN_HIGH = 2'd1;
  localparam logic [1:0] PIN_HIZ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MODULE_NUMBER = 1'b0;
  localparam logic CFG_OPEN_DRAIN    = 1'b1;

  localparam logic [3:0] MODULE_NUMBER_RESET = 4'd1;
  localparam logic [3:0] MODULE_NUMBER_MAX   = 4'd8;
  localparam logic [7:0] CONTROL_MASK        = 8'h3F;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  reg_select;
    logic [7:0]  write_data;
    logic        pin_high;
    logic [2:0]  match_timer;
    logic [15:0] timer1_count;
    logic [7:0]  timer2_count;
    logic [15:0] timer3_count;
    logic [7:0]  timer4_count;
  } ccp_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] read_mask;
    logic       read_hit;
    logic [7:0] write_mask;
    logic [1:0] pin_drive;
    logic       pin_changed;
    logic       interrupt_flag;
    logic       special_event;
    logic [2:0] special_timer;
  } ccp_result_t;

endpackage

// File: hdl/ccp_core.sv
// Unit state and per-transaction event logic.
`timescale 1ns / 1ps
module ccp_core import ccp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        advance,
  input  ccp_item_t   item,
  output ccp_result_t result
);

  logic [3:0]  module_number;
  logic        open_drain_output;
  logic [3:0]  mode_bits, mode_bits_next;
  logic        timer_pair_select, timer_pair_select_next;
  logic        out_latch, out_latch_next;
  logic [15:0] capture_compare_value, capture_compare_value_next;
  logic [9:0]  duty_latched, duty_latched_next;
  logic [1:0]  duty_low_bits, duty_low_bits_next;
  logic [3:0]  edge_prescale_count, edge_prescale_count_next;

  logic        in_capture, in_compare, in_pwm, sel_ok, cap_hit, cap_event;
  logic        cap_next, swi_next;
  logic [2:0]  bit_idx, active_tmr;
  logic [3:0]  prescale_inc;
  logic [15:0] tmr_count;

  always_comb begin
    in_capture = (mode_bits[3:2] == 2'b01);
    in_pwm     = (mode_bits[3:2] == 2'b11);
    in_compare = (mode_bits == MODE_CMP_TOGGLE) || (mode_bits[3:2] == 2'b10);
    sel_ok     = (module_number != 4'd0) && (module_number <= MODULE_NUMBER_MAX);
    bit_idx    = sel_ok ? 3'(module_number - 4'd1) : 3'd0;

    if (in_pwm) begin
      active_tmr = timer_pair_select ? TMR4 : TMR2;
      tmr_count  = timer_pair_select ? {8'd0, item.timer4_count} : {8'd0, item.timer2_count};
    end else begin
      active_tmr = timer_pair_select ? TMR3 : TMR1;
      tmr_count  = timer_pair_select ? item.timer3_count : item.timer1_count;
    end

    // prescaled capture: counter wraps at 16, divider 1, 4 or 16
    prescale_inc = edge_prescale_count + 4'd1;
    if (mode_bits == MODE_CAP_4TH) begin
      cap_hit = (prescale_inc[1:0] == 2'd0);
    end else if (mode_bits == MODE_CAP_16TH) begin
      cap_hit = (prescale_inc == 4'd0);
    end else begin
      cap_hit = 1'b1;
    end

    mode_bits_next             = mode_bits;
    timer_pair_select_next     = timer_pair_select;
    out_latch_next             = out_latch;
    capture_compare_value_next = capture_compare_value;
    duty_latched_next          = duty_latched;
    duty_low_bits_next         = duty_low_bits;
    edge_prescale_count_next   = edge_prescale_count;
    result                     = '0;
    cap_event                  = 1'b0;

    case (item.req_type)
      REQ_TICK: begin
        if (in_compare) begin
          if (tmr_count == capture_compare_value) begin
            result.interrupt_flag = 1'b1;
            if (mode_bits == MODE_CMP_SPECIAL) begin
              result.special_event = 1'b1;
              result.special_timer = active_tmr;
            end else if (mode_bits == MODE_CMP_TOGGLE) begin
              out_latch_next     = ~out_latch;
              result.pin_changed = 1'b1;
            end else if (mode_bits == MODE_CMP_SET) begin
              out_latch_next     = 1'b1;
              result.pin_changed = 1'b1;
            end else if (mode_bits == MODE_CMP_CLR) begin
              out_latch_next     = 1'b0;
              result.pin_changed = 1'b1;
            end
          end
        end else if (in_pwm) begin
          if (tmr_count[7:0] == duty_latched[9:2]) begin
            out_latch_next     = 1'b0;
            result.pin_changed = 1'b1;
          end
        end
      end
      REQ_PIN: begin
        // falling edge in the falling mode, rising edge otherwise
        cap_event = in_capture && (item.pin_high == (mode_bits != MODE_CAP_FALL));
      end
      REQ_PWM_MATCH: begin
        if (in_pwm && (item.match_timer == active_tmr)) begin
          duty_latched_next = {capture_compare_value[15:8], duty_low_bits};
          if (duty_latched_next != 10'd0) begin
            out_latch_next     = 1'b1;
            result.pin_changed = 1'b1;
          end
        end
      end
      REQ_CAN_CAP: begin
        cap_event = in_capture;
      end
      REQ_READ: begin
        case (item.reg_select)
          SEL_VAL_HI: begin
            result.read_data = capture_compare_value[15:8];
            result.read_mask = 8'hFF;
            result.read_hit  = 1'b1;
          end
          SEL_VAL_LO: begin
            result.read_data = capture_compare_value[7:0];
            result.read_mask = 8'hFF;
            result.read_hit  = 1'b1;
          end
          SEL_CONTROL: begin
            result.read_data = {2'b00, duty_low_bits, mode_bits};
            result.read_mask = CONTROL_MASK;
            result.read_hit  = 1'b1;
          end
          SEL_TMR_SEL: begin
            if (sel_ok) begin
              result.read_data = {7'd0, timer_pair_select} << bit_idx;
              result.read_mask = 8'd1 << bit_idx;
              result.read_hit  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_select)
          SEL_VAL_HI: begin
            // high byte holds the duty cycle in PWM: locked
            if (!in_pwm) begin
              capture_compare_value_next[15:8] = item.write_data;
              result.write_mask                = 8'hFF;
            end
          end
          SEL_VAL_LO: begin
            capture_compare_value_next[7:0] = item.write_data;
            result.write_mask               = 8'hFF;
          end
          SEL_CONTROL: begin
            mode_bits_next     = item.write_data[3:0];
            duty_low_bits_next = item.write_data[5:4];
            result.write_mask  = CONTROL_MASK;
          end
          SEL_TMR_SEL: begin
            if (sel_ok) begin
              timer_pair_select_next = item.write_data[bit_idx];
              result.write_mask      = 8'd1 << bit_idx;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (cap_event) begin
      edge_prescale_count_next = prescale_inc;
      result.interrupt_flag    = cap_hit;
      if (cap_hit) begin
        capture_compare_value_next = tmr_count;
      end
    end

    // pin state after this transaction
    cap_next = (mode_bits_next[3:2] == 2'b01);
    swi_next = (mode_bits_next == MODE_CMP_SWI) || (mode_bits_next == MODE_CMP_SPECIAL);
    if (cap_next || swi_next) begin
      result.pin_drive = PIN_HIZ;
    end else if (!out_latch_next) begin
      result.pin_drive = PIN_LOW;
    end else begin
      result.pin_drive = open_drain_output ? PIN_HIZ : PIN_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_number         <= MODULE_NUMBER_RESET;
      open_drain_output     <= 1'b0;
      mode_bits             <= '0;
      timer_pair_select     <= 1'b0;
      out_latch             <= 1'b0;
      capture_compare_value <= '0;
      duty_latched          <= '0;
      duty_low_bits         <= '0;
      edge_prescale_count   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULE_NUMBER: module_number <= cfg_data;
          CFG_OPEN_DRAIN:    open_drain_output <= cfg_data[0];
          default: ;
        endcase
      end
      if (advance) begin
        mode_bits             <= mode_bits_next;
        timer_pair_select     <= timer_pair_select_next;
        out_latch             <= out_latch_next;
        capture_compare_value <= capture_compare_value_next;
        duty_latched          <= duty_latched_next;
        duty_low_bits         <= duty_low_bits_next;
        edge_prescale_count   <= edge_prescale_count_next;
      end
    end
  end

endmodule

// File: hdl/capture_compare_pwm_unit.sv
// Capture/compare/PWM unit: top level with input and result registers.
// Each transaction passes through an input register and then a result register.
// Throughput: one transaction per cycle while m_tready holds; the event logic between the two registers
//   reads the unit state and computes its update combinationally, so events follow back to back.
// A stalled result register holds its transaction while one more waits in the input register.
// Reset (synchronous, rst high): both stages empty, mode disabled, value and duty zero,
//   module number 1, push-pull output.
`timescale 1ns / 1ps
`include "capture_compare_pwm_unit_defines.svh"
module capture_compare_pwm_unit import ccp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  // event stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  // write_data[7:0], pin_high[8], match_timer[11:9], timer1_count[27:12],
  // timer2_count[35:28], timer3_count[51:36], timer4_count[59:52], zero fill
  input  logic [63:0] s_tdata,
  // req_type[2:0], reg_select[5:3]
  input  logic [5:0]  s_tuser,
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], read_mask[15:8], read_hit[16], write_mask[24:17],
  // pin_drive[26:25], pin_changed[27], interrupt_flag[28], special_event[29],
  // special_timer[32:30], zero fill
  output logic [39:0] m_tdata
);

  ccp_item_t   item_q;
  logic        in_valid;
  ccp_result_t res_d, res_q;
  logic        out_valid;
  logic        advance;

  // the input stage moves on when the result register is empty or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_q.req_type     <= s_tuser[2:0];
      item_q.reg_select   <= s_tuser[5:3];
      item_q.write_data   <= s_tdata[7:0];
      item_q.pin_high     <= s_tdata[8];
      item_q.match_timer  <= s_tdata[11:9];
      item_q.timer1_count <= s_tdata[27:12];
      item_q.timer2_count <= s_tdata[35:28];
      item_q.timer3_count <= s_tdata[51:36];
      item_q.timer4_count <= s_tdata[59:52];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  ccp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item_q),
    .result    (res_d)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, res_q.special_timer, res_q.special_event, res_q.interrupt_flag,
                     res_q.pin_changed, res_q.pin_drive, res_q.write_mask, res_q.read_hit,
                     res_q.read_mask, res_q.read_data};

  `CCP_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> (!in_valid && !out_valid), "stages not empty after reset")
  `CCP_ASSERT(a_no_drop_on_stall, (in_valid && out_valid && !m_tready) |=> in_valid, "input transaction lost while result stalled")
  `CCP_ASSERT(a_special_irq, (out_valid && res_q.special_event) |-> res_q.interrupt_flag, "special event without interrupt")
  `CCP_ASSERT(a_read_miss_zero, (out_valid && !res_q.read_hit) |-> (res_q.read_data == 8'd0 && res_q.read_mask == 8'd0), "read data on a miss")
  `CCP_ASSERT(a_read_write_excl, out_valid |-> !(res_q.read_hit && res_q.write_mask != 8'd0), "read and write in one result")

endmodule
